// ----- rtl/sm_pkg.sv -----
package sm_pkg;

  localparam int CAPACITY = 1024;
  localparam int ADDR_W   = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CNT_W    = $clog2(CAPACITY + 1);
  localparam int DATA_W   = 32;

  // flipping the sign bit maps signed order onto unsigned order
  localparam logic [DATA_W-1:0] SIGN_BIT = {1'b1, {(DATA_W-1){1'b0}}};

  typedef struct packed {
    logic signed [DATA_W-1:0] value;
    logic                     value_is_null;
    logic                     end_of_set;
  } sm_in_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] median;
    logic                     median_is_null;
    logic                     capacity_overflow;
  } sm_out_t;

  // per-cycle control from the sequencer to each rank lane
  typedef struct packed {
    logic              start;
    logic              hit;
    logic              commit;
    logic [DATA_W-1:0] cur;
    logic [DATA_W-1:0] above;
  } sm_ctl_t;

endpackage

// ----- rtl/sm_store.sv -----
module sm_store import sm_pkg::*; (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [DATA_W-1:0] wdata,
  input  logic [ADDR_W-1:0] raddr,
  output logic [DATA_W-1:0] rdata
);

  logic [DATA_W-1:0] mem [CAPACITY];

  // write one sample
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

// ----- rtl/sm_rank.sv -----
module sm_rank import sm_pkg::*; (
  input  logic              clk,
  input  sm_ctl_t           ctl,
  input  logic [CNT_W-1:0]  k,
  input  logic [DATA_W-1:0] data,
  output logic [DATA_W-1:0] prefix
);

  logic [CNT_W-1:0] rank;
  logic [CNT_W-1:0] cnt;
  logic             match;

  // sample agrees with the decided upper bits and has a zero at the current bit
  assign match = (((data ^ prefix) & ctl.above) == '0) && ((data & ctl.cur) == '0);

  // count matches over one pass, then settle one bit of the selected value
  always_ff @(posedge clk) begin
    if (ctl.start) begin
      prefix <= '0;
      rank   <= k;
      cnt    <= '0;
    end else if (ctl.commit) begin
      if (cnt <= rank) begin
        rank   <= rank - cnt;
        prefix <= prefix | ctl.cur;
      end
      cnt <= '0;
    end else if (ctl.hit && match) begin
      cnt <= cnt + CNT_W'(1);
    end
  end

endmodule

// ----- rtl/set_median.sv -----
// Loading: one word per cycle; item_ready is high only while the set is loading.
// Median: after the end-of-set word, 32 bit passes over the store, each reading every
//   kept sample once through the single-port read of the sample store; an empty set
//   skips the passes and goes straight to the result.
// Reset (rst, synchronous, active high) empties the set and clears result_valid;
//   the result word and the sample store itself are not cleared.
module set_median import sm_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  logic    item_valid,
  output logic    item_ready,
  input  sm_in_t  item,
  output logic    result_valid,
  input  logic    result_ready,
  output sm_out_t result
);

  typedef enum logic [2:0] {
    S_LOAD = 3'b001,
    S_SCAN = 3'b010,
    S_DONE = 3'b100
  } state_t;

  state_t            state;
  logic [CNT_W-1:0]  count;
  logic              dropped;
  logic [CNT_W-1:0]  idx;
  logic              rd_valid;
  logic [DATA_W-1:0] cur;
  logic [DATA_W-1:0] above;

  logic              accept;
  logic              store_it;
  logic [CNT_W-1:0]  count_next;
  logic [CNT_W-1:0]  mid;
  logic [CNT_W-1:0]  k_lo;
  logic [CNT_W-1:0]  k_hi;
  logic              pass_end;
  logic [DATA_W-1:0] rdata;
  logic [DATA_W-1:0] prefix_lo;
  logic [DATA_W-1:0] prefix_hi;
  logic [DATA_W-1:0] val_lo;
  logic [DATA_W-1:0] val_hi;
  logic [DATA_W:0]   sum;
  logic [DATA_W:0]   sum_adj;
  sm_ctl_t           ctl;

  assign item_ready = (state == S_LOAD);
  assign accept     = item_valid && item_ready;
  assign store_it   = accept && !item.value_is_null && (count < CNT_W'(CAPACITY));
  assign count_next = store_it ? count + CNT_W'(1) : count;

  // ranks of the two middle samples; equal for an odd count
  assign mid  = count_next >> 1;
  assign k_hi = mid;
  assign k_lo = count_next[0] ? mid : mid - CNT_W'(1);

  assign pass_end = (state == S_SCAN) && (idx == count) && !rd_valid;

  assign ctl.start  = accept && item.end_of_set;
  assign ctl.hit    = (state == S_SCAN) && rd_valid;
  assign ctl.commit = pass_end;
  assign ctl.cur    = cur;
  assign ctl.above  = above;

  sm_store u_store (
    .clk   (clk),
    .we    (store_it),
    .waddr (count[ADDR_W-1:0]),
    .wdata (item.value ^ SIGN_BIT),
    .raddr (idx[ADDR_W-1:0]),
    .rdata (rdata)
  );

  sm_rank u_rank_lo (
    .clk    (clk),
    .ctl    (ctl),
    .k      (k_lo),
    .data   (rdata),
    .prefix (prefix_lo)
  );

  sm_rank u_rank_hi (
    .clk    (clk),
    .ctl    (ctl),
    .k      (k_hi),
    .data   (rdata),
    .prefix (prefix_hi)
  );

  // average the two middle samples, truncating toward zero
  assign val_lo  = prefix_lo ^ SIGN_BIT;
  assign val_hi  = prefix_hi ^ SIGN_BIT;
  assign sum     = {val_lo[DATA_W-1], val_lo} + {val_hi[DATA_W-1], val_hi};
  assign sum_adj = sum + {{DATA_W{1'b0}}, sum[DATA_W]};

  // sequencer: load, scan bit by bit, hand off the result
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_LOAD;
      count        <= '0;
      dropped      <= 1'b0;
      idx          <= '0;
      rd_valid     <= 1'b0;
      cur          <= SIGN_BIT;
      above        <= '0;
      result_valid <= 1'b0;
    end else begin
      // drop the taken word unless a new one replaces it this cycle
      if (result_valid && result_ready && (state != S_DONE)) begin
        result_valid <= 1'b0;
      end
      case (state)
        S_LOAD: begin
          if (accept) begin
            count <= count_next;
            if (!item.value_is_null && (count >= CNT_W'(CAPACITY))) begin
              dropped <= 1'b1;
            end
            if (item.end_of_set) begin
              idx      <= '0;
              rd_valid <= 1'b0;
              cur      <= SIGN_BIT;
              above    <= '0;
              state    <= (count_next == '0) ? S_DONE : S_SCAN;
            end
          end
        end
        S_SCAN: begin
          // issue one read a cycle, then close the pass once the last word is counted
          rd_valid <= (idx < count);
          if (idx < count) begin
            idx <= idx + CNT_W'(1);
          end
          if (pass_end) begin
            idx   <= '0;
            cur   <= cur >> 1;
            above <= {1'b1, above[DATA_W-1:1]};
            if (cur[0]) begin
              state <= S_DONE;
            end
          end
        end
        S_DONE: begin
          if (!result_valid || result_ready) begin
            result_valid <= 1'b1;
            count        <= '0;
            dropped      <= 1'b0;
            state        <= S_LOAD;
          end
        end
        default: begin
          state <= S_LOAD;
        end
      endcase
    end
  end

  // result word; no reset needed
  always_ff @(posedge clk) begin
    if ((state == S_DONE) && (!result_valid || result_ready)) begin
      result.median            <= (count == '0) ? '0 : sum_adj[DATA_W:1];
      result.median_is_null    <= (count == '0);
      result.capacity_overflow <= dropped;
    end
  end

endmodule
